### design/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring fifo with block admission.
// ----------------------------------------------------------------------------
package brf_pkg;

    // payload widths
    localparam int FUNC_W = 2;
    localparam int SIZE_W = 13;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // judge the block and move one byte
        logic resp;   // present the result for one cycle
    } t_ctrl_cmd;

endpackage

### design/brf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer: capture an item, execute it, present its result.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output brf_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_busy     = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.resp = (r_state == S_RESP);

endmodule

### design/brf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_dp
// Datapath: ring memory, pointers, fill count, block admission and capacity.
// ----------------------------------------------------------------------------
module brf_dp #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brf_pkg::t_ctrl_cmd          i_cmd,
    input  logic                        i_cfg_we,
    input  logic [brf_pkg::SIZE_W-1:0]  i_cfg_capacity,
    input  logic [brf_pkg::FUNC_W-1:0]  i_func,
    input  logic [brf_pkg::SIZE_W-1:0]  i_block_size,
    input  logic                        i_first,
    input  logic [brf_pkg::BYTE_W-1:0]  i_data_byte,
    output logic [brf_pkg::DATA_W-1:0]  o_capacity,
    output logic                        o_accepted,
    output logic [brf_pkg::BYTE_W-1:0]  o_data_out,
    output logic [brf_pkg::SIZE_W-1:0]  o_fill_level,
    output logic                        o_last
);

    localparam int AW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int SW = (CW > brf_pkg::SIZE_W) ? CW : brf_pkg::SIZE_W;
    localparam logic [SW-1:0] MAX_CAP_S = SW'(MAX_CAPACITY);

    // ring memory, no reset
    logic [brf_pkg::BYTE_W-1:0] r_mem [MAX_CAPACITY];
    logic [brf_pkg::BYTE_W-1:0] r_rd_data;

    // fifo and block state
    logic [AW-1:0]             r_rp, n_rp;
    logic [AW-1:0]             r_wp, n_wp;
    logic [CW-1:0]             r_fill, n_fill;
    logic [CW-1:0]             r_cap;
    logic [brf_pkg::SIZE_W-1:0] r_rem, n_rem;
    logic                      r_admit, n_admit;

    // captured item
    logic [brf_pkg::FUNC_W-1:0] r_func;
    logic [brf_pkg::SIZE_W-1:0] r_size;
    logic                       r_first;
    logic [brf_pkg::BYTE_W-1:0] r_byte;

    // result registers
    logic r_acc, n_acc;
    logic r_last, n_last;
    logic r_moved, n_moved;
    logic mem_we;

    // capacity write value, clamped to 1..MAX_CAPACITY
    logic [SW-1:0] cfg_val_s;
    logic [CW-1:0] cfg_cap;

    always_comb begin
        cfg_val_s = SW'(i_cfg_capacity);
        if (cfg_val_s == '0) begin
            cfg_cap = CW'(1);
        end else if (cfg_val_s > MAX_CAP_S) begin
            cfg_cap = CW'(MAX_CAPACITY);
        end else begin
            cfg_cap = CW'(cfg_val_s);
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_size  <= i_block_size;
            r_first <= i_first;
            r_byte  <= i_data_byte;
        end
    end

    // block judgment and single byte move
    logic [SW-1:0] size_s;
    logic [SW-1:0] cap_s;
    logic [SW-1:0] fill_s;
    logic [SW-1:0] free_s;
    logic          ok;
    logic          active;
    logic          admit_eff;
    logic [brf_pkg::SIZE_W-1:0] rem_eff;
    logic [CW-1:0] wp_inc;
    logic [CW-1:0] rp_inc;

    always_comb begin
        size_s    = SW'(r_size);
        cap_s     = SW'(r_cap);
        fill_s    = SW'(r_fill);
        free_s    = cap_s - fill_s;
        wp_inc    = CW'(r_wp) + CW'(1);
        rp_inc    = CW'(r_rp) + CW'(1);
        ok        = 1'b0;
        active    = 1'b1;
        admit_eff = r_admit;
        rem_eff   = r_rem;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_rem     = r_rem;
        n_admit   = r_admit;
        n_acc     = 1'b0;
        n_last    = 1'b0;
        n_moved   = 1'b0;
        mem_we    = 1'b0;

        if (r_func != brf_pkg::FUNC_WRITE && r_func != brf_pkg::FUNC_READ) begin
            // query: report fill only
            n_acc  = 1'b1;
            n_last = 1'b1;
        end else begin
            if (r_first) begin
                if (r_func == brf_pkg::FUNC_WRITE) begin
                    ok = (size_s != '0) && (size_s <= cap_s) && (size_s <= free_s);
                end else begin
                    ok = (size_s != '0) && (size_s <= fill_s);
                end
                admit_eff = ok;
                rem_eff   = r_size;
                n_admit   = ok;
                n_rem     = r_size;
                if (r_size == '0) begin
                    active = 1'b0;
                    n_last = 1'b1;
                end
            end else if (r_rem == '0) begin
                active = 1'b0;
            end

            if (active) begin
                n_acc = admit_eff;
                if (admit_eff) begin
                    if (r_func == brf_pkg::FUNC_WRITE && r_fill < r_cap) begin
                        mem_we = 1'b1;
                        n_wp   = (wp_inc >= r_cap) ? '0 : AW'(wp_inc);
                        n_fill = r_fill + CW'(1);
                    end else if (r_func == brf_pkg::FUNC_READ && r_fill != '0) begin
                        n_moved = 1'b1;
                        n_rp    = (rp_inc >= r_cap) ? '0 : AW'(rp_inc);
                        n_fill  = r_fill - CW'(1);
                    end
                end
                n_rem = rem_eff - brf_pkg::SIZE_W'(1);
                if (n_rem == '0) begin
                    n_last  = 1'b1;
                    n_admit = 1'b0;
                end
            end
        end
    end

    // memory write and registered read at the read pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[r_wp] <= r_byte;
        end
        r_rd_data <= r_mem[r_rp];
    end

    // control state: capacity write empties the fifo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CW'(MAX_CAPACITY);
            r_rp    <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_rem   <= '0;
            r_admit <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap   <= cfg_cap;
            r_rp    <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_rem   <= '0;
            r_admit <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_rem   <= n_rem;
            r_admit <= n_admit;
        end
    end

    // result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_acc   <= n_acc;
            r_last  <= n_last;
            r_moved <= n_moved;
        end
    end

    // result outputs, valid while the controller presents them
    assign o_accepted   = r_acc;
    assign o_last       = r_last;
    assign o_data_out   = r_moved ? r_rd_data : '0;
    assign o_fill_level = brf_pkg::SIZE_W'(r_fill);
    assign o_capacity   = brf_pkg::DATA_W'(r_cap);

endmodule

### design/byte_ring_fifo_block_admit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_admit
// Byte ring fifo that admits whole write or read blocks or rejects them.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Busy then stays high
// through the execute and the result state. In the execute state the item is
// executed against the pointers and the ring memory. The memory is written at
// the write pointer, and the byte at the read pointer is read into a register
// at the same edge. In the result state the result is on the o_ ports with
// o_valid high for exactly one cycle. A new item is taken only once busy is
// low again, so an item is never taken before the result of the last one is
// out. The receiver cannot stall results. The ring memory needs no clearing
// after reset: a byte is only read after it was written. Writing the capacity
// register empties the fifo and closes any open block; write it only while
// busy is low.
module byte_ring_fifo_block_admit #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [brf_pkg::FUNC_W-1:0]  i_func,
    input  logic [brf_pkg::SIZE_W-1:0]  i_block_size,
    input  logic                        i_first,
    input  logic [brf_pkg::BYTE_W-1:0]  i_data_byte,
    // result channel
    output logic                        o_valid,
    output logic                        o_accepted,
    output logic [brf_pkg::BYTE_W-1:0]  o_data_out,
    output logic [brf_pkg::SIZE_W-1:0]  o_fill_level,
    output logic                        o_last,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brf_pkg::ADDR_W-1:0]  paddr,
    input  logic [brf_pkg::DATA_W-1:0]  pwdata,
    output logic [brf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    brf_pkg::t_ctrl_cmd          cmd;
    logic                        cfg_we;
    logic [brf_pkg::DATA_W-1:0]  capacity;

    // register decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == brf_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == brf_pkg::REG_CAPACITY) ? capacity : '0;

    brf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    brf_dp #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (cfg_we),
        .i_cfg_capacity (pwdata[brf_pkg::SIZE_W-1:0]),
        .i_func         (i_func),
        .i_block_size   (i_block_size),
        .i_first        (i_first),
        .i_data_byte    (i_data_byte),
        .o_capacity     (capacity),
        .o_accepted     (o_accepted),
        .o_data_out     (o_data_out),
        .o_fill_level   (o_fill_level),
        .o_last         (o_last)
    );

    // result strobe
    assign o_valid = cmd.resp;

endmodule

### design/brf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks of command and result timing and of rejected-item data.
// ----------------------------------------------------------------------------
module brf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        o_valid,
    input  logic                        o_accepted,
    input  logic [brf_pkg::BYTE_W-1:0]  o_data_out
);

    // a taken transaction makes the block busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transaction was taken");

    // a taken transaction is followed by its result strobe
    a_resp_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result not presented two cycles after the transaction");

    // results appear only while busy and last one cycle
    a_resp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy ##1 !o_valid)
        else $error("result strobe outside a busy single cycle");

    // a rejected item returns no data
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_data_out == '0))
        else $error("data returned on a rejected item");

endmodule

bind byte_ring_fifo_block_admit brf_checker u_brf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_accepted (o_accepted),
    .o_data_out (o_data_out)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring fifo with block admission. A typed
// table of directed transactions runs first, then randomized block traffic
// over a range of ring capacities. An in-bench ring model predicts every
// result; the monitor holds typed rows to the table and the rest to the model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_MAX = 4096;

    // item functions beyond the two the package names
    localparam logic [brf_pkg::FUNC_W-1:0] FUNC_QUERY    = 2'd2;
    localparam logic [brf_pkg::FUNC_W-1:0] FUNC_QUERY_HI = 2'd3;

    // byte address of the capacity register
    localparam logic [brf_pkg::ADDR_W-1:0] CAP_ADDR = {brf_pkg::REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic [brf_pkg::FUNC_W-1:0] func;
        logic [brf_pkg::SIZE_W-1:0] block_size;
        logic                       first;
        logic [brf_pkg::BYTE_W-1:0] data_byte;
    } t_fifo_item;

    typedef struct packed {
        logic                       accepted;
        logic [brf_pkg::BYTE_W-1:0] data_out;
        logic [brf_pkg::SIZE_W-1:0] fill_level;
        logic                       last;
    } t_fifo_result;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // a config row carries the capacity value in block_size
    typedef struct packed {
        t_row_kind    kind;
        t_fifo_item   item;
        logic         typed;
        t_fifo_result res;
    } t_dir_row;

    localparam t_fifo_result NO_RES = '0;
    localparam int DIR_ROWS = 27;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // query at reset, read block on an empty ring, stray item, empty block
        '{ROW_ITEM, '{FUNC_QUERY, 13'd0, 1'b0, 8'h00}, 1'b1, '{1'b1, 8'h00, 13'd0, 1'b1}},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd1, 1'b1, 8'h00}, 1'b1,
          '{1'b0, 8'h00, 13'd0, 1'b1}},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd4096, 1'b0, 8'hff}, 1'b1,
          '{1'b0, 8'h00, 13'd0, 1'b0}},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b1, 8'h00}, 1'b1,
          '{1'b0, 8'h00, 13'd0, 1'b1}},
        // byte extremes in and out, oversized block rejected, query inside a block
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd2, 1'b1, 8'h00}, 1'b1,
          '{1'b1, 8'h00, 13'd1, 1'b0}},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b0, 8'hff}, 1'b1,
          '{1'b1, 8'h00, 13'd2, 1'b1}},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd4096, 1'b1, 8'h5a}, 1'b1,
          '{1'b0, 8'h00, 13'd2, 1'b0}},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd2, 1'b1, 8'h00}, 1'b1,
          '{1'b1, 8'h00, 13'd1, 1'b0}},
        '{ROW_ITEM, '{FUNC_QUERY_HI, 13'd0, 1'b0, 8'h00}, 1'b1,
          '{1'b1, 8'h00, 13'd1, 1'b1}},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd0, 1'b0, 8'h00}, 1'b1,
          '{1'b1, 8'hff, 13'd0, 1'b1}},
        // capacity zero acts as one byte
        '{ROW_CFG, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd1, 1'b1, 8'h81}, 1'b1,
          '{1'b1, 8'h00, 13'd1, 1'b1}},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd1, 1'b1, 8'h7e}, 1'b1,
          '{1'b0, 8'h00, 13'd1, 1'b1}},
        // three byte ring: fill it, then a read block whose writes refill it
        '{ROW_CFG, '{brf_pkg::FUNC_WRITE, 13'd3, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd3, 1'b1, 8'h11}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b0, 8'h22}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b0, 8'h33}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd3, 1'b1, 8'h00}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b0, 8'h44}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd0, 1'b0, 8'h55}, 1'b0, NO_RES},
        // capacity above the maximum, then a write block whose reads drain the ring
        '{ROW_CFG, '{brf_pkg::FUNC_WRITE, 13'd8191, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd3, 1'b1, 8'h66}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd0, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd0, 1'b0, 8'h00}, 1'b0, NO_RES},
        // capacity write closes an open block
        '{ROW_ITEM, '{brf_pkg::FUNC_WRITE, 13'd3, 1'b1, 8'h77}, 1'b0, NO_RES},
        '{ROW_CFG, '{brf_pkg::FUNC_WRITE, 13'd3, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{ROW_ITEM, '{brf_pkg::FUNC_READ, 13'd0, 1'b0, 8'h00}, 1'b1,
          '{1'b0, 8'h00, 13'd0, 1'b0}}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [brf_pkg::FUNC_W-1:0]  i_func = '0;
    logic [brf_pkg::SIZE_W-1:0]  i_block_size = '0;
    logic                        i_first = 1'b0;
    logic [brf_pkg::BYTE_W-1:0]  i_data_byte = '0;
    logic                        o_valid;
    logic                        o_accepted;
    logic [brf_pkg::BYTE_W-1:0]  o_data_out;
    logic [brf_pkg::SIZE_W-1:0]  o_fill_level;
    logic                        o_last;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [brf_pkg::ADDR_W-1:0]  paddr = '0;
    logic [brf_pkg::DATA_W-1:0]  pwdata = '0;
    logic [brf_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // ring model state
    logic [brf_pkg::BYTE_W-1:0]  ring_mem [RING_MAX];
    int                          rd_pos = 0;
    int                          wr_pos = 0;
    bit                          ring_full = 1'b0;
    int                          ring_cap = RING_MAX;
    int                          blk_left = 0;
    bit                          blk_ok = 1'b0;

    t_fifo_result                ring_results_q [$];
    int                          mismatch_cnt = 0;

    byte_ring_fifo_block_admit #(
        .MAX_CAPACITY (RING_MAX)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_block_size (i_block_size),
        .i_first      (i_first),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .o_accepted   (o_accepted),
        .o_data_out   (o_data_out),
        .o_fill_level (o_fill_level),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    // bytes held in the ring model
    function automatic int ring_fill();
        if (wr_pos == rd_pos)
            return ring_full ? ring_cap : 0;
        if (wr_pos > rd_pos)
            return wr_pos - rd_pos;
        return ring_cap - rd_pos + wr_pos;
    endfunction

    // apply one item to the ring model and return the result it gives
    function automatic t_fifo_result ring_step(input t_fifo_item it);
        t_fifo_result r;
        bit           live;
        int           fl;
        int           sz;
        r  = '0;
        sz = int'(it.block_size);
        if (it.func != brf_pkg::FUNC_WRITE && it.func != brf_pkg::FUNC_READ) begin
            r.accepted = 1'b1;
            r.last     = 1'b1;
        end else begin
            live = 1'b1;
            // block is judged once, on its opening item
            if (it.first) begin
                fl = ring_fill();
                if (it.func == brf_pkg::FUNC_WRITE)
                    blk_ok = sz != 0 && sz <= ring_cap && sz <= ring_cap - fl;
                else
                    blk_ok = sz != 0 && sz <= fl;
                blk_left = sz;
                if (sz == 0) begin
                    live   = 1'b0;
                    r.last = 1'b1;
                end
            end else if (blk_left == 0) begin
                live = 1'b0;
            end
            if (live) begin
                r.accepted = blk_ok;
                if (blk_ok) begin
                    fl = ring_fill();
                    if (it.func == brf_pkg::FUNC_WRITE && fl < ring_cap) begin
                        ring_mem[wr_pos] = it.data_byte;
                        wr_pos = (wr_pos + 1 >= ring_cap) ? 0 : wr_pos + 1;
                        if (wr_pos == rd_pos)
                            ring_full = 1'b1;
                    end else if (it.func == brf_pkg::FUNC_READ && fl > 0) begin
                        r.data_out = ring_mem[rd_pos];
                        rd_pos = (rd_pos + 1 >= ring_cap) ? 0 : rd_pos + 1;
                        ring_full = 1'b0;
                    end
                end
                blk_left--;
                if (blk_left == 0) begin
                    r.last = 1'b1;
                    blk_ok = 1'b0;
                end
            end
        end
        r.fill_level = brf_pkg::SIZE_W'(ring_fill());
        return r;
    endfunction

    // present one transaction and hold it until the block takes it
    task automatic push_item(input t_fifo_item it, input logic typed,
                             input t_fifo_result res);
        t_fifo_result pred;
        start        <= 1'b1;
        i_func       <= it.func;
        i_block_size <= it.block_size;
        i_first      <= it.first;
        i_data_byte  <= it.data_byte;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pred = ring_step(it);
        ring_results_q.push_back(typed ? res : pred);
    endtask

    // optional idle burst ahead of a transaction
    task automatic offer_item(input t_fifo_item it, input int gap_pct);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge i_clk);
        end
        push_item(it, 1'b0, NO_RES);
    endtask

    // drain, let the pipeline settle, then write the capacity register
    task automatic write_capacity(input logic [brf_pkg::SIZE_W-1:0] value);
        int v;
        start <= 1'b0;
        while (ring_results_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (4)
            @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CAP_ADDR;
        pwdata  <= brf_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // out-of-range values are clamped, and the ring empties
        v = int'(value);
        if (v == 0)
            v = 1;
        if (v > RING_MAX)
            v = RING_MAX;
        ring_cap  = v;
        rd_pos    = 0;
        wr_pos    = 0;
        ring_full = 1'b0;
        blk_left  = 0;
        blk_ok    = 1'b0;
    endtask

    // one capacity setting with random block traffic
    task automatic run_phase(input logic [brf_pkg::SIZE_W-1:0] cap_val, input int quota,
                             input bit calm);
        int                         sent;
        int                         roll;
        int                         fl;
        int                         lim;
        int                         n;
        int                         gap;
        logic [brf_pkg::SIZE_W-1:0] bsize;
        logic [brf_pkg::FUNC_W-1:0] bfunc;
        t_fifo_item                 it;
        write_capacity(cap_val);
        sent = 0;
        while (sent < quota) begin
            gap  = (calm || $urandom_range(0, 2) == 0) ? 0 : 30;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                // noise: a non-opening item, possibly with no block open
                it.func       = brf_pkg::FUNC_W'($urandom_range(0, 3));
                it.block_size = brf_pkg::SIZE_W'($urandom_range(0, 4096));
                it.first      = 1'b0;
                it.data_byte  = brf_pkg::BYTE_W'($urandom_range(0, 255));
                offer_item(it, gap);
                sent++;
            end else if (roll < 10) begin
                it.func       = brf_pkg::FUNC_W'($urandom_range(2, 3));
                it.block_size = brf_pkg::SIZE_W'($urandom_range(0, 4096));
                it.first      = ($urandom_range(0, 1) != 0);
                it.data_byte  = brf_pkg::BYTE_W'($urandom_range(0, 255));
                offer_item(it, gap);
                sent++;
            end else begin
                fl = ring_fill();
                if (fl == 0)
                    bfunc = brf_pkg::FUNC_WRITE;
                else if (fl == ring_cap)
                    bfunc = brf_pkg::FUNC_READ;
                else
                    bfunc = $urandom_range(0, 1) ? brf_pkg::FUNC_READ : brf_pkg::FUNC_WRITE;
                lim = (bfunc == brf_pkg::FUNC_WRITE) ? ring_cap - fl : fl;
                // block size: mostly admissible, some empty, oversized or huge
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    bsize = '0;
                else if (roll < 8)
                    bsize = brf_pkg::SIZE_W'($urandom_range(0, 4096));
                else if (roll < 18)
                    bsize = (lim + 3 > 4096) ? 13'd4096
                                             : brf_pkg::SIZE_W'(lim + $urandom_range(1, 3));
                else
                    bsize = brf_pkg::SIZE_W'($urandom_range(1, (lim > 24) ? 24 : lim));
                n = (bsize == 0) ? 1 : int'(bsize);
                if (n > 24)
                    n = $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(1, n);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        it.func       = brf_pkg::FUNC_W'($urandom_range(2, 3));
                        it.block_size = brf_pkg::SIZE_W'($urandom_range(0, 4096));
                        it.first      = 1'b0;
                        it.data_byte  = brf_pkg::BYTE_W'($urandom_range(0, 255));
                        offer_item(it, gap);
                        sent++;
                    end
                    // later items may switch direction within the block
                    if (k == 0 || $urandom_range(0, 6) != 0)
                        it.func = bfunc;
                    else
                        it.func = (bfunc == brf_pkg::FUNC_WRITE) ? brf_pkg::FUNC_READ
                                                                 : brf_pkg::FUNC_WRITE;
                    it.block_size = (k == 0) ? bsize
                                             : brf_pkg::SIZE_W'($urandom_range(0, 4096));
                    it.first      = (k == 0);
                    it.data_byte  = brf_pkg::BYTE_W'($urandom_range(0, 255));
                    offer_item(it, gap);
                    sent++;
                end
            end
        end
    endtask

    // result monitor, fields in the order accepted, data, fill, last
    always @(posedge i_clk) begin : result_check
        t_fifo_result got;
        t_fifo_result want;
        if (i_rst_n && o_valid) begin
            got = '{o_accepted, o_data_out, o_fill_level, o_last};
            if (ring_results_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: expected none, got %0d %02h %0d %0d",
                         $time, got.accepted, got.data_out, got.fill_level, got.last);
            end else begin
                want = ring_results_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    $display("%0t: expected %0d %02h %0d %0d, got %0d %02h %0d %0d",
                             $time, want.accepted, want.data_out, want.fill_level,
                             want.last, got.accepted, got.data_out, got.fill_level,
                             got.last);
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [brf_pkg::SIZE_W-1:0] phase_cap [10];
        phase_cap = '{13'd1, 13'd2, 13'd5, 13'd0, 13'd4096, 13'd16, 13'd0, 13'd8191,
                      13'd0, 13'd0};
        phase_cap[3] = brf_pkg::SIZE_W'($urandom_range(3, 40));
        phase_cap[6] = brf_pkg::SIZE_W'($urandom_range(41, 700));
        phase_cap[9] = brf_pkg::SIZE_W'($urandom_range(3, 12));

        repeat (5)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_capacity(dir_rows[i].item.block_size);
            else
                push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        end

        // random traffic, no idling in the closing phase
        for (int p = 0; p < 10; p++)
            run_phase(phase_cap[p], 110, p == 9);

        start <= 1'b0;
        while (ring_results_q.size() != 0)
            @(posedge i_clk);
        repeat (8)
            @(posedge i_clk);
        if (mismatch_cnt == 0 && ring_results_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
